// File: design/dreq_pkg.sv
package dreq_pkg;

  localparam int unsigned DefQueueDepth     = 64;
  localparam int unsigned DefTrackBits      = 10;
  localparam int unsigned DefMaxSectorIndex = 15;

  localparam int unsigned CfgBits         = 11;
  localparam int unsigned KindBits        = 2;
  localparam int unsigned StatusBits      = 2;
  localparam int unsigned RequesterBits   = 6;
  localparam int unsigned SectorBits      = 4;
  localparam int unsigned CountBits       = 8;
  localparam int unsigned SectorLimitBits = 8;

  localparam logic [CfgBits-1:0] TrackCountReset = 11'd1024;

  typedef enum logic [KindBits-1:0] {
    KindEnqueue = 2'd0,
    KindDequeue = 2'd1,
    KindSetHead = 2'd2
  } kind_e;

  typedef enum logic [StatusBits-1:0] {
    StatusOk      = 2'd0,
    StatusInvalid = 2'd1,
    StatusFull    = 2'd2,
    StatusEmpty   = 2'd3
  } status_e;

  typedef struct packed {
    logic start;
    logic take;
    logic give;
  } slot_ctl_t;

endpackage

// File: design/disk_elevator_request_queue_core.sv
// Circular-scan request queue for one disk.
// The input channel (in_valid_i, in_stall_o) carries one item: an enqueue,
// a dequeue or a new head track, selected by kind_i. Each item gives exactly
// one result on the output channel (out_valid_o, out_stall_i) with a status
// and, for a successful dequeue, the fields of the popped request.
// The track count register (reset 1024) is set via cfg_we_i and cfg_wdata_i;
// the user writes it only while the block is idle; the block does not check.
// A set-head item or a rejected item goes from StCheck straight to StResp; a
// dequeue passes through StDeq. An accepted enqueue walks the linked list
// one entry per cycle through the synchronous entry and link memories, while
// a slot scanner looks for the lowest free slot one bit per cycle. It is
// written in StInsNew once the walk ends and a free slot is found, and passes
// through StInsPrev when it is linked in after an existing entry.
// One item is in flight at a time, so the next item can be accepted in the
// same cycle as the result appears.
// in_stall_o is high from acceptance until the result is handed to the
// output register. That register holds the result while out_stall_i is high,
// and the next item may be accepted meanwhile.
// Reset empties the queue, frees all slots and clears the head track.
module disk_elevator_request_queue_core #(
  parameter int unsigned QueueDepth     = dreq_pkg::DefQueueDepth,
  parameter int unsigned TrackBits      = dreq_pkg::DefTrackBits,
  parameter int unsigned MaxSectorIndex = dreq_pkg::DefMaxSectorIndex
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dreq_pkg::CfgBits-1:0]       cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [dreq_pkg::KindBits-1:0]      kind_i,
  input  logic [dreq_pkg::RequesterBits-1:0] requester_i,
  input  logic [TrackBits-1:0]               track_i,
  input  logic [dreq_pkg::SectorBits-1:0]    start_sector_i,
  input  logic [dreq_pkg::CountBits-1:0]     sector_count_i,
  input  logic                               is_write_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [dreq_pkg::StatusBits-1:0]    status_o,
  output logic [dreq_pkg::RequesterBits-1:0] out_requester_o,
  output logic [TrackBits-1:0]               out_track_o,
  output logic [dreq_pkg::SectorBits-1:0]    out_start_sector_o,
  output logic [dreq_pkg::CountBits-1:0]     out_sector_count_o,
  output logic                               out_is_write_o
);

  localparam int unsigned IdxBits   = $clog2(QueueDepth);
  localparam int unsigned CntBits   = $clog2(QueueDepth + 1);
  localparam int unsigned CountLsb  = 1;
  localparam int unsigned StartLsb  = CountLsb + dreq_pkg::CountBits;
  localparam int unsigned TrackLsb  = StartLsb + dreq_pkg::SectorBits;
  localparam int unsigned ReqLsb    = TrackLsb + TrackBits;
  localparam int unsigned EntryBits = ReqLsb + dreq_pkg::RequesterBits;
  localparam int unsigned CmpBits   =
    (TrackBits > dreq_pkg::CfgBits) ? TrackBits : dreq_pkg::CfgBits;

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StWalk,
    StInsNew,
    StInsPrev,
    StDeq,
    StResp
  } state_e;

  state_e                        state_q, state_d;
  logic [dreq_pkg::CfgBits-1:0]  track_count_q, track_count_d;
  logic [dreq_pkg::KindBits-1:0] kind_q, kind_d;
  logic [EntryBits-1:0]          item_q, item_d;
  logic [IdxBits-1:0]            head_index_q, head_index_d;
  logic [CntBits-1:0]            count_q, count_d;
  logic [TrackBits-1:0]          head_track_q, head_track_d;
  logic [IdxBits-1:0]            cur_q, cur_d;
  logic [IdxBits-1:0]            prev_q, prev_d;
  logic [TrackBits-1:0]          prev_track_q, prev_track_d;
  logic                          have_prev_q, have_prev_d;
  logic [CntBits-1:0]            left_q, left_d;
  dreq_pkg::status_e             res_status_q, res_status_d;
  logic [EntryBits-1:0]          res_entry_q, res_entry_d;
  logic                          out_valid_q, out_valid_d;
  dreq_pkg::status_e             out_status_q, out_status_d;
  logic [EntryBits-1:0]          out_entry_q, out_entry_d;

  logic                 entry_we;
  logic                 link_we;
  logic [IdxBits-1:0]   link_waddr;
  logic [IdxBits-1:0]   link_wdata;
  logic [IdxBits-1:0]   rd_addr;
  logic [EntryBits-1:0] entry_rd;
  logic [IdxBits-1:0]   link_rd;
  dreq_pkg::slot_ctl_t  slot_ctl;
  logic [IdxBits-1:0]   free_slot;
  logic                 slot_found;

  logic [TrackBits-1:0] item_track;
  logic [TrackBits-1:0] node_track;
  logic                 bad_params;
  logic                 is_full;
  logic                 fits_here;

  dreq_store #(
    .QueueDepth(QueueDepth),
    .EntryBits (EntryBits)
  ) u_store (
    .clk_i        (clk_i),
    .entry_we_i   (entry_we),
    .entry_waddr_i(free_slot),
    .entry_wdata_i(item_q),
    .link_we_i    (link_we),
    .link_waddr_i (link_waddr),
    .link_wdata_i (link_wdata),
    .rd_addr_i    (rd_addr),
    .entry_rd_o   (entry_rd),
    .link_rd_o    (link_rd)
  );

  dreq_slot_scan #(
    .QueueDepth(QueueDepth)
  ) u_slot_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (slot_ctl),
    .give_idx_i(head_index_q),
    .slot_o    (free_slot),
    .found_o   (slot_found)
  );

  assign item_track = item_q[TrackLsb +: TrackBits];
  assign node_track = entry_rd[TrackLsb +: TrackBits];

  assign bad_params =
    (dreq_pkg::SectorLimitBits'(item_q[StartLsb +: dreq_pkg::SectorBits]) >
     dreq_pkg::SectorLimitBits'(MaxSectorIndex)) ||
    (CmpBits'(item_track) >= CmpBits'(track_count_q));

  assign is_full = (count_q == CntBits'(QueueDepth));

  assign fits_here =
    ((prev_track_q < item_track) && (item_track < node_track)) ||
    ((prev_track_q > node_track) &&
     ((item_track > prev_track_q) || (item_track < node_track)));

  always_comb begin
    state_d       = state_q;
    track_count_d = track_count_q;
    kind_d        = kind_q;
    item_d        = item_q;
    head_index_d  = head_index_q;
    count_d       = count_q;
    head_track_d  = head_track_q;
    cur_d         = cur_q;
    prev_d        = prev_q;
    prev_track_d  = prev_track_q;
    have_prev_d   = have_prev_q;
    left_d        = left_q;
    res_status_d  = res_status_q;
    res_entry_d   = res_entry_q;
    out_valid_d   = out_valid_q;
    out_status_d  = out_status_q;
    out_entry_d   = out_entry_q;
    entry_we      = 1'b0;
    link_we       = 1'b0;
    link_waddr    = free_slot;
    link_wdata    = cur_q;
    rd_addr       = cur_q;
    slot_ctl      = '0;

    if (cfg_we_i) begin
      track_count_d = cfg_wdata_i;
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          kind_d  = kind_i;
          item_d  = {requester_i, track_i, start_sector_i, sector_count_i, is_write_i};
          state_d = StCheck;
        end
      end
      StCheck: begin
        res_entry_d  = '0;
        res_status_d = dreq_pkg::StatusOk;
        state_d      = StResp;
        unique case (kind_q)
          dreq_pkg::KindEnqueue: begin
            if (bad_params) begin
              res_status_d = dreq_pkg::StatusInvalid;
            end else if (is_full) begin
              res_status_d = dreq_pkg::StatusFull;
            end else begin
              slot_ctl.start = 1'b1;
              rd_addr        = head_index_q;
              cur_d          = head_index_q;
              prev_track_d   = head_track_q;
              have_prev_d    = 1'b0;
              left_d         = count_q;
              state_d        = (count_q == '0) ? StInsNew : StWalk;
            end
          end
          dreq_pkg::KindDequeue: begin
            if (count_q == '0) begin
              res_status_d = dreq_pkg::StatusEmpty;
            end else begin
              rd_addr = head_index_q;
              state_d = StDeq;
            end
          end
          dreq_pkg::KindSetHead: begin
            head_track_d = item_track;
          end
          default: begin
            res_status_d = dreq_pkg::StatusInvalid;
          end
        endcase
      end
      StWalk: begin
        if (fits_here) begin
          state_d = StInsNew;
        end else begin
          have_prev_d  = 1'b1;
          prev_d       = cur_q;
          prev_track_d = node_track;
          cur_d        = link_rd;
          rd_addr      = link_rd;
          left_d       = left_q - 1'b1;
          if (left_q == CntBits'(1)) begin
            state_d = StInsNew;
          end
        end
      end
      StInsNew: begin
        if (slot_found) begin
          entry_we      = 1'b1;
          link_we       = 1'b1;
          slot_ctl.take = 1'b1;
          count_d       = count_q + 1'b1;
          if (have_prev_q) begin
            state_d = StInsPrev;
          end else begin
            head_index_d = free_slot;
            state_d      = StResp;
          end
        end
      end
      StInsPrev: begin
        link_we    = 1'b1;
        link_waddr = prev_q;
        link_wdata = free_slot;
        state_d    = StResp;
      end
      StDeq: begin
        res_entry_d   = entry_rd;
        head_index_d  = link_rd;
        slot_ctl.give = 1'b1;
        count_d       = count_q - 1'b1;
        head_track_d  = node_track;
        state_d       = StResp;
      end
      StResp: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_entry_d  = res_entry_q;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      track_count_q <= dreq_pkg::TrackCountReset;
      head_index_q  <= '0;
      count_q       <= '0;
      head_track_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      track_count_q <= track_count_d;
      head_index_q  <= head_index_d;
      count_q       <= count_d;
      head_track_q  <= head_track_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    item_q       <= item_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    prev_track_q <= prev_track_d;
    have_prev_q  <= have_prev_d;
    left_q       <= left_d;
    res_status_q <= res_status_d;
    res_entry_q  <= res_entry_d;
    out_status_q <= out_status_d;
    out_entry_q  <= out_entry_d;
  end

  assign in_stall_o         = (state_q != StIdle);
  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign out_requester_o    = out_entry_q[ReqLsb +: dreq_pkg::RequesterBits];
  assign out_track_o        = out_entry_q[TrackLsb +: TrackBits];
  assign out_start_sector_o = out_entry_q[StartLsb +: dreq_pkg::SectorBits];
  assign out_sector_count_o = out_entry_q[CountLsb +: dreq_pkg::CountBits];
  assign out_is_write_o     = out_entry_q[0];

endmodule

// File: design/dreq_store.sv
module dreq_store #(
  parameter int unsigned QueueDepth = dreq_pkg::DefQueueDepth,
  parameter int unsigned EntryBits  = 29
) (
  input  logic                          clk_i,
  input  logic                          entry_we_i,
  input  logic [$clog2(QueueDepth)-1:0] entry_waddr_i,
  input  logic [EntryBits-1:0]          entry_wdata_i,
  input  logic                          link_we_i,
  input  logic [$clog2(QueueDepth)-1:0] link_waddr_i,
  input  logic [$clog2(QueueDepth)-1:0] link_wdata_i,
  input  logic [$clog2(QueueDepth)-1:0] rd_addr_i,
  output logic [EntryBits-1:0]          entry_rd_o,
  output logic [$clog2(QueueDepth)-1:0] link_rd_o
);

  localparam int unsigned IdxBits = $clog2(QueueDepth);

  logic [EntryBits-1:0] entry_mem [QueueDepth];
  logic [IdxBits-1:0]   link_mem  [QueueDepth];

  always_ff @(posedge clk_i) begin
    if (entry_we_i) begin
      entry_mem[entry_waddr_i] <= entry_wdata_i;
    end
    entry_rd_o <= entry_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (link_we_i) begin
      link_mem[link_waddr_i] <= link_wdata_i;
    end
    link_rd_o <= link_mem[rd_addr_i];
  end

endmodule

// File: design/dreq_slot_scan.sv
module dreq_slot_scan #(
  parameter int unsigned QueueDepth = dreq_pkg::DefQueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dreq_pkg::slot_ctl_t           ctl_i,
  input  logic [$clog2(QueueDepth)-1:0] give_idx_i,
  output logic [$clog2(QueueDepth)-1:0] slot_o,
  output logic                          found_o
);

  localparam int unsigned IdxBits = $clog2(QueueDepth);

  logic [QueueDepth-1:0] free_q;
  logic [IdxBits-1:0]    scan_q;
  logic                  found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q  <= '1;
      scan_q  <= '0;
      found_q <= 1'b0;
    end else begin
      if (ctl_i.start) begin
        scan_q  <= '0;
        found_q <= 1'b0;
      end else if (!found_q) begin
        if (free_q[scan_q]) begin
          found_q <= 1'b1;
        end else begin
          scan_q <= scan_q + 1'b1;
        end
      end
      if (ctl_i.take) begin
        free_q[scan_q] <= 1'b0;
      end
      if (ctl_i.give) begin
        free_q[give_idx_i] <= 1'b1;
      end
    end
  end

  assign slot_o  = scan_q;
  assign found_o = found_q;

endmodule

// File: design/dreq_checker.sv
module dreq_checker #(
  parameter int unsigned TrackBits = dreq_pkg::DefTrackBits
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [dreq_pkg::StatusBits-1:0]    status_o,
  input logic [dreq_pkg::RequesterBits-1:0] out_requester_o,
  input logic [TrackBits-1:0]               out_track_o,
  input logic [dreq_pkg::SectorBits-1:0]    out_start_sector_o,
  input logic [dreq_pkg::CountBits-1:0]     out_sector_count_o,
  input logic                               out_is_write_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(out_track_o)))
    else $error("A stalled result changed or was dropped.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("The block accepted two items in back-to-back cycles.");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !$rose(out_valid_o))
    else $error("A result appeared one cycle after an item was accepted.");

  a_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != dreq_pkg::StatusOk)) |->
      ((out_requester_o == '0) && (out_track_o == '0) &&
       (out_start_sector_o == '0) && (out_sector_count_o == '0) &&
       (out_is_write_o == 1'b0)))
    else $error("A failed item returned nonzero request fields.");

endmodule

bind disk_elevator_request_queue_core dreq_checker #(
  .TrackBits(TrackBits)
) u_dreq_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .status_o          (status_o),
  .out_requester_o   (out_requester_o),
  .out_track_o       (out_track_o),
  .out_start_sector_o(out_start_sector_o),
  .out_sector_count_o(out_sector_count_o),
  .out_is_write_o    (out_is_write_o)
);

// File: tb/testbench.sv
module testbench;

  localparam int unsigned QDepth = dreq_pkg::DefQueueDepth;
  localparam int unsigned TBits = dreq_pkg::DefTrackBits;
  localparam int unsigned MaxSector = dreq_pkg::DefMaxSectorIndex;
  localparam int unsigned CfgW = dreq_pkg::CfgBits;
  localparam int unsigned KindW = dreq_pkg::KindBits;
  localparam int unsigned StW = dreq_pkg::StatusBits;
  localparam int unsigned ReqW = dreq_pkg::RequesterBits;
  localparam int unsigned SecW = dreq_pkg::SectorBits;
  localparam int unsigned CntW = dreq_pkg::CountBits;
  localparam logic [KindW-1:0] KindUnknown = 2'd3;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = QDepth + 16;
  localparam int unsigned HoldAfter = 60;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ReqW-1:0]  requester;
    logic [TBits-1:0] track;
    logic [SecW-1:0]  start_sector;
    logic [CntW-1:0]  sector_count;
    logic             is_write;
  } dreq_item_t;

  typedef struct packed {
    logic [StW-1:0]   status;
    logic [ReqW-1:0]  requester;
    logic [TBits-1:0] track;
    logic [SecW-1:0]  start_sector;
    logic [CntW-1:0]  sector_count;
    logic             is_write;
  } dreq_result_t;

  class dreq_scoreboard;
    logic [CfgW-1:0]  track_count;
    dreq_item_t       entries [QDepth];
    int unsigned      links [QDepth];
    bit               slot_free [QDepth];
    int unsigned      head_index;
    int unsigned      entry_count;
    logic [TBits-1:0] head_track;
    dreq_result_t     expected_q [$];
    int unsigned      errors;

    function new();
      track_count = dreq_pkg::TrackCountReset;
      head_index = 0;
      entry_count = 0;
      head_track = '0;
      errors = 0;
      foreach (slot_free[i]) begin
        slot_free[i] = 1'b1;
        links[i] = 0;
      end
    endfunction

    // Elevator insertion: place the request before the first node whose track and
    // the track before it (or the head track) bracket it strictly or across the wrap.
    function dreq_pkg::status_e link_request(dreq_item_t rq);
      int unsigned      slot;
      int unsigned      prev;
      int unsigned      cur;
      int unsigned      left;
      int               i;
      bit               have_prev;
      logic [TBits-1:0] prev_track;
      logic [TBits-1:0] nt;
      if (rq.start_sector > MaxSector || rq.track >= track_count) begin
        return dreq_pkg::StatusInvalid;
      end
      if (entry_count >= QDepth) return dreq_pkg::StatusFull;
      slot = 0;
      for (i = int'(QDepth) - 1; i >= 0; i--) begin
        if (slot_free[i]) slot = unsigned'(i);
      end
      have_prev = 1'b0;
      prev = 0;
      prev_track = head_track;
      cur = head_index;
      left = entry_count;
      while (left > 0) begin
        nt = entries[cur].track;
        if ((prev_track < rq.track && rq.track < nt) ||
            (prev_track > nt && (rq.track > prev_track || rq.track < nt))) break;
        have_prev = 1'b1;
        prev = cur;
        prev_track = nt;
        cur = links[cur];
        left--;
      end
      entries[slot] = rq;
      slot_free[slot] = 1'b0;
      if (have_prev) begin
        links[slot] = links[prev];
        links[prev] = slot;
      end else begin
        links[slot] = head_index;
        head_index = slot;
      end
      entry_count++;
      return dreq_pkg::StatusOk;
    endfunction

    function void note_input(dreq_item_t it);
      dreq_result_t res;
      dreq_item_t   popped;
      res = '0;
      case (it.kind)
        dreq_pkg::KindEnqueue: begin
          res.status = link_request(it);
        end
        dreq_pkg::KindDequeue: begin
          if (entry_count == 0) begin
            res.status = dreq_pkg::StatusEmpty;
          end else begin
            popped = entries[head_index];
            slot_free[head_index] = 1'b1;
            head_index = links[head_index];
            entry_count--;
            head_track = popped.track;
            res.status = dreq_pkg::StatusOk;
            res.requester = popped.requester;
            res.track = popped.track;
            res.start_sector = popped.start_sector;
            res.sector_count = popped.sector_count;
            res.is_write = popped.is_write;
          end
        end
        dreq_pkg::KindSetHead: begin
          head_track = it.track;
          res.status = dreq_pkg::StatusOk;
        end
        default: begin
          res.status = dreq_pkg::StatusInvalid;
        end
      endcase
      expected_q.push_back(res);
    endfunction

    function void check_result(dreq_result_t got);
      dreq_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("Unexpected result item: status %0d requester %0d track %0d",
                   got.status, got.requester, got.track);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.requester !== want.requester ||
          got.track !== want.track || got.start_sector !== want.start_sector ||
          got.sector_count !== want.sector_count ||
          got.is_write !== want.is_write) begin
        errors++;
        if (errors <= MaxReports)
          $display({"Mismatch: expected st %0d rq %0d trk %0d ss %0d cnt %0d wr %0d,",
                    " got st %0d rq %0d trk %0d ss %0d cnt %0d wr %0d"},
                   want.status, want.requester, want.track, want.start_sector,
                   want.sector_count, want.is_write, got.status, got.requester,
                   got.track, got.start_sector, got.sector_count, got.is_write);
      end
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CfgW-1:0]          cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [KindW-1:0]         kind_i;
  logic [ReqW-1:0]          requester_i;
  logic [TBits-1:0]         track_i;
  logic [SecW-1:0]          start_sector_i;
  logic [CntW-1:0]          sector_count_i;
  logic                     is_write_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [StW-1:0]           status_o;
  logic [ReqW-1:0]          out_requester_o;
  logic [TBits-1:0]         out_track_o;
  logic [SecW-1:0]          out_start_sector_o;
  logic [CntW-1:0]          out_sector_count_o;
  logic                     out_is_write_o;

  dreq_scoreboard sb;
  int unsigned    tx_idle_pct;
  int unsigned    rx_idle_pct;
  int unsigned    cycle_count = 0;

  disk_elevator_request_queue_core u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .kind_i             (kind_i),
    .requester_i        (requester_i),
    .track_i            (track_i),
    .start_sector_i     (start_sector_i),
    .sector_count_i     (sector_count_i),
    .is_write_i         (is_write_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .out_requester_o    (out_requester_o),
    .out_track_o        (out_track_o),
    .out_start_sector_o (out_start_sector_o),
    .out_sector_count_o (out_sector_count_o),
    .out_is_write_o     (out_is_write_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_item(input logic [KindW-1:0] kind, input logic [ReqW-1:0] rq,
                           input logic [TBits-1:0] trk, input logic [SecW-1:0] ss,
                           input logic [CntW-1:0] cnt, input logic wr);
    dreq_item_t it;
    it = '{kind, rq, trk, ss, cnt, wr};
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= it.kind;
    requester_i <= it.requester;
    track_i <= it.track;
    start_sector_i <= it.start_sector;
    sector_count_i <= it.sector_count;
    is_write_i <= it.is_write;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_track_count(input logic [CfgW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.track_count = value;
  endtask

  task automatic run_random(input int unsigned n, input int unsigned enq_pct);
    int unsigned      r;
    int unsigned      span;
    logic [KindW-1:0] k;
    logic [TBits-1:0] trk;
    repeat (n) begin
      r = $urandom_range(99);
      span = (sb.track_count == 0 || sb.track_count > 1024) ? 1024 : sb.track_count;
      if (span < 1024 && $urandom_range(9) == 0) trk = TBits'($urandom_range(1023, span));
      else trk = TBits'($urandom_range(span - 1));
      if (r < enq_pct) begin
        k = dreq_pkg::KindEnqueue;
      end else if (r < 95) begin
        k = dreq_pkg::KindDequeue;
      end else if (r < 99) begin
        k = dreq_pkg::KindSetHead;
        trk = TBits'($urandom_range(1023));
      end else begin
        k = KindUnknown;
      end
      send_item(k, ReqW'($urandom_range(63)), trk, SecW'($urandom_range(15)),
                CntW'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    dreq_result_t got;
    int unsigned  results_seen;
    int unsigned  hold_left;
    bit           hold_done;
    results_seen = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got = '{status_o, out_requester_o, out_track_o, out_start_sector_o,
                out_sector_count_o, out_is_write_o};
        sb.check_result(got);
        results_seen++;
      end
      if (!hold_done && results_seen == HoldAfter) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  initial begin
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    kind_i = dreq_pkg::KindEnqueue;
    requester_i = '0;
    track_i = '0;
    start_sector_i = '0;
    sector_count_i = '0;
    is_write_i = 1'b0;
    tx_idle_pct = 36;
    rx_idle_pct = 47;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_track_count(11'd1024);
    send_item(dreq_pkg::KindDequeue, 6'd5, 10'd77, 4'd3, 8'd9, 1'b1);
    send_item(dreq_pkg::KindSetHead, 6'd0, 10'd500, 4'd0, 8'd0, 1'b0);
    send_item(dreq_pkg::KindEnqueue, 6'd63, 10'd600, 4'd15, 8'd255, 1'b1);
    send_item(dreq_pkg::KindEnqueue, 6'd0, 10'd400, 4'd0, 8'd0, 1'b0);
    send_item(dreq_pkg::KindEnqueue, 6'd21, 10'd700, 4'd7, 8'd128, 1'b1);
    send_item(dreq_pkg::KindEnqueue, 6'd42, 10'd550, 4'd8, 8'd1, 1'b0);
    send_item(dreq_pkg::KindEnqueue, 6'd1, 10'd1023, 4'd1, 8'd254, 1'b1);
    send_item(dreq_pkg::KindEnqueue, 6'd62, 10'd0, 4'd14, 8'd127, 1'b0);
    send_item(dreq_pkg::KindEnqueue, 6'd33, 10'd600, 4'd2, 8'd64, 1'b1);
    send_item(KindUnknown, 6'd63, 10'd1023, 4'd15, 8'd255, 1'b1);
    send_item(dreq_pkg::KindSetHead, 6'd0, 10'd1023, 4'd0, 8'd0, 1'b0);
    repeat (8) send_item(dreq_pkg::KindDequeue, 6'd0, 10'd0, 4'd0, 8'd0, 1'b0);

    drain();
    write_track_count(11'd600);
    send_item(dreq_pkg::KindEnqueue, 6'd10, 10'd600, 4'd4, 8'd10, 1'b0);
    send_item(dreq_pkg::KindEnqueue, 6'd11, 10'd599, 4'd5, 8'd11, 1'b1);
    send_item(dreq_pkg::KindDequeue, 6'd0, 10'd0, 4'd0, 8'd0, 1'b0);

    drain();
    write_track_count(11'd0);
    send_item(dreq_pkg::KindEnqueue, 6'd12, 10'd0, 4'd0, 8'd12, 1'b1);

    drain();
    write_track_count(11'd1);
    send_item(dreq_pkg::KindEnqueue, 6'd13, 10'd0, 4'd6, 8'd13, 1'b0);
    send_item(dreq_pkg::KindEnqueue, 6'd14, 10'd1, 4'd9, 8'd14, 1'b1);
    send_item(dreq_pkg::KindDequeue, 6'd0, 10'd0, 4'd0, 8'd0, 1'b0);

    drain();
    write_track_count(11'd2047);
    send_item(dreq_pkg::KindEnqueue, 6'd15, 10'd1023, 4'd10, 8'd15, 1'b1);
    send_item(dreq_pkg::KindDequeue, 6'd0, 10'd0, 4'd0, 8'd0, 1'b0);

    drain();
    write_track_count(11'd1024);
    run_random(100, 92);
    run_random(50, 10);

    drain();
    tx_idle_pct = 47;
    rx_idle_pct = 36;
    write_track_count(CfgW'($urandom_range(32, 1)));
    run_random(100, 92);
    drain();
    run_random(50, 10);

    drain();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_track_count(CfgW'($urandom_range(1024, 1)));
    run_random(70, 92);
    run_random(80, 10);

    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
